>>> design/tcw_pkg.sv
// Shared constants and control types of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry
  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);

  // Field widths
  localparam int KIND_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int IDX_W   = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Character codes and attributes
  localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0F;

  // Controller to datapath commands
  typedef struct packed {
    logic put_char;   // apply a character item at the cursor
    logic home;       // clear item: home cursor, clear result fields
    logic res_clear;  // zero cell and scroll result fields
    logic cell_load;  // capture read data into the result
    logic cnt_inc;    // advance sweep counter
    logic cnt_zero;   // restart sweep counter
    logic fill_en;    // write fill value at sweep counter
    logic fill_init;  // fill with the reset cell rather than current blank
    logic copy_rd;    // scroll copy: read one row below the sweep counter
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_scroll;  // character item at the input would scroll
    logic idx_ok;       // read index lies on the screen
    logic last_copy;    // sweep counter at last cell of the copy region
    logic last_cell;    // sweep counter at last cell of the screen
  } dp_stat_t;

endpackage

>>> design/tcw_ctrl.sv
// Sequencing state machine of the text console writer.
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tcw_pkg::KIND_W-1:0] in_kind,
  input  tcw_pkg::dp_stat_t         stat,
  output tcw_pkg::dp_cmd_t          cmd,
  output logic                      busy,
  output logic                      out_valid
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_COPY  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.fill_en   = 1'b1;
        cmd.fill_init = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (stat.last_cell) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (in_kind)
            tcw_pkg::KIND_CHAR: begin
              cmd.put_char = 1'b1;
              if (stat.need_scroll) begin
                cmd.cnt_zero = 1'b1;
                state_nxt    = S_COPY;
              end else begin
                state_nxt = S_RESP;
              end
            end
            tcw_pkg::KIND_CLEAR: begin
              cmd.home     = 1'b1;
              cmd.cnt_zero = 1'b1;
              state_nxt    = S_FILL;
            end
            tcw_pkg::KIND_READ: begin
              if (stat.idx_ok) begin
                state_nxt = S_READ;
              end else begin
                cmd.res_clear = 1'b1;
                state_nxt     = S_RESP;
              end
            end
            default: begin
              cmd.res_clear = 1'b1;
              state_nxt     = S_RESP;
            end
          endcase
        end
      end
      S_COPY: begin
        cmd.copy_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.last_copy) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last copied cell is written this cycle; counter already at bottom row
        state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.fill_en = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.last_cell) begin
          state_nxt = S_RESP;
        end
      end
      S_READ: begin
        cmd.cell_load = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

endmodule

>>> design/tcw_datapath.sv
// Cursor, colour register, sweep counter and screen store of the console writer.
`timescale 1ns / 1ps

module tcw_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tcw_pkg::dp_cmd_t             cmd,
  output tcw_pkg::dp_stat_t            stat,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::IDX_W-1:0]    in_read_index,
  input  logic                         cfg_we,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_text_color,
  output logic [tcw_pkg::POS_W-1:0]    out_cursor_pos,
  output logic [tcw_pkg::CELL_W-1:0]   out_cell_value,
  output logic                         out_scrolled
);

  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int CELL_W = tcw_pkg::CELL_W;
  localparam int POS_W  = tcw_pkg::POS_W;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(tcw_pkg::CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'((tcw_pkg::ROWS - 1) * tcw_pkg::COLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(tcw_pkg::COLS);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(tcw_pkg::COLS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(tcw_pkg::ROWS - 1);
  localparam logic [CELL_W-1:0] RESET_CELL = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE};

  logic [tcw_pkg::COLOR_W-1:0] color_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] cnt_r;
  logic              copy_wr_r;
  logic [ADDR_W-1:0] copy_addr_r;
  logic [CELL_W-1:0] rd_data_r;
  logic [CELL_W-1:0] cell_r;
  logic              scrolled_r;
  logic [CELL_W-1:0] mem [tcw_pkg::CELLS];

  logic              is_nl, is_bs, row_adv, need_scroll;
  logic [ADDR_W-1:0] lin;
  logic              we;
  logic [ADDR_W-1:0] wa, ra;
  logic [CELL_W-1:0] wd;

  // Cursor step for a character item
  always_comb begin
    is_nl   = (in_char_code == tcw_pkg::CH_NEWLINE);
    is_bs   = (in_char_code == tcw_pkg::CH_BACKSPACE);
    col_nxt = col_r;
    row_adv = 1'b0;
    if (is_nl) begin
      col_nxt = '0;
      row_adv = 1'b1;
    end else if (is_bs) begin
      if (col_r != '0) begin
        col_nxt = col_r - 1'b1;
      end
    end else if (col_r == COL_LAST) begin
      col_nxt = '0;
      row_adv = 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
    end
    need_scroll = row_adv && (row_r == ROW_LAST);
    row_nxt     = (row_adv && !need_scroll) ? row_r + 1'b1 : row_r;
  end

  assign lin = ADDR_W'(row_r) * ROW_STEP + ADDR_W'(col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r    <= tcw_pkg::RESET_COLOR;
      col_r      <= '0;
      row_r      <= '0;
      cnt_r      <= '0;
      copy_wr_r  <= 1'b0;
      scrolled_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        color_r <= cfg_text_color;
      end
      if (cmd.put_char) begin
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        scrolled_r <= need_scroll;
      end else if (cmd.home) begin
        col_r      <= '0;
        row_r      <= '0;
        scrolled_r <= 1'b0;
      end else if (cmd.res_clear || cmd.cell_load) begin
        scrolled_r <= 1'b0;
      end
      if (cmd.cnt_zero) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= (cnt_r == LAST_CELL) ? '0 : cnt_r + 1'b1;
      end
      copy_wr_r <= cmd.copy_rd;
    end
  end

  always_ff @(posedge clk) begin
    copy_addr_r <= cnt_r;
    if (cmd.put_char || cmd.home || cmd.res_clear) begin
      cell_r <= '0;
    end else if (cmd.cell_load) begin
      cell_r <= rd_data_r;
    end
  end

  // Single write port: pending copy beat, then fill, then character
  always_comb begin
    we = 1'b0;
    wa = cnt_r;
    wd = {color_r, tcw_pkg::CH_SPACE};
    if (copy_wr_r) begin
      we = 1'b1;
      wa = copy_addr_r;
      wd = rd_data_r;
    end else if (cmd.fill_en) begin
      we = 1'b1;
      wd = cmd.fill_init ? RESET_CELL : {color_r, tcw_pkg::CH_SPACE};
    end else if (cmd.put_char && !is_nl && !is_bs) begin
      we = 1'b1;
      wa = lin;
      wd = {color_r, in_char_code};
    end
  end

  assign ra = cmd.copy_rd ? cnt_r + ROW_STEP : ADDR_W'(in_read_index);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  assign stat.need_scroll = need_scroll;
  assign stat.idx_ok      = (int'(in_read_index) < tcw_pkg::CELLS);
  assign stat.last_copy   = (cnt_r == LAST_COPY);
  assign stat.last_cell   = (cnt_r == LAST_CELL);

  assign out_cursor_pos = POS_W'(lin);
  assign out_cell_value = cell_r;
  assign out_scrolled   = scrolled_r;

endmodule

>>> design/text_console_writer_top.sv
// Top level of the text console writer: controller and datapath.
`timescale 1ns / 1ps

// Channel   | Ports                                         | Beat taken when
// ----------+-----------------------------------------------+---------------------------
// input     | start, busy, in_kind, in_char_code,           | start high, busy low
//           | in_read_index                                 |
// result    | out_valid, out_cursor_pos, out_cell_value,    | out_valid high (one cycle)
//           | out_scrolled                                  |
// config    | cfg_valid, cfg_ready, cfg_text_color          | cfg_valid and cfg_ready
//
// Steps per item, set by the single-write-port screen store swept one cell a cycle:
//   plain character, backspace, newline, unused kind, off-screen read: result state only
//   on-screen read: registered store read, then result state
//   clear: fill of all CELLS cells, then result state; character or newline that scrolls:
//   row copy of (ROWS-1)*COLS cells, the drain state, bottom row fill of COLS cells, result.
// After reset a clearing pass writes white spaces over all 2000 cells, with busy
//   high throughout. Config writes are always taken (cfg_ready tied high).
// Results are a one-cycle strobe; the receiver cannot stall them.

module text_console_writer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [tcw_pkg::KIND_W-1:0]   in_kind,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::IDX_W-1:0]    in_read_index,
  output logic                         out_valid,
  output logic [tcw_pkg::POS_W-1:0]    out_cursor_pos,
  output logic [tcw_pkg::CELL_W-1:0]   out_cell_value,
  output logic                         out_scrolled,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_text_color
);

  tcw_pkg::dp_cmd_t  cmd;
  tcw_pkg::dp_stat_t stat;

  // user must change the colour register only while idle (the block does not enforce this); no back-pressure
  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tcw_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_char_code   (in_char_code),
    .in_read_index  (in_read_index),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_text_color (cfg_text_color),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_value (out_cell_value),
    .out_scrolled   (out_scrolled)
  );

endmodule
